@@ rtl/srwm_pkg.sv @@
// ----------------------------------------------------------------------------
// srwm_pkg
// Shared types, constants and helpers of the sensor ready window monitor.
// ----------------------------------------------------------------------------
package srwm_pkg;

  localparam int unsigned COUNTER_BITS = 16;
  localparam int unsigned TIME_BITS    = 48;
  localparam int unsigned NCH          = 5;
  localparam int unsigned DIV_NW       = TIME_BITS;
  localparam int unsigned DIV_DW       = 32;
  localparam int unsigned PROD_W       = 30;
  localparam int unsigned DIV_CW       = $clog2(DIV_NW + 1);

  localparam logic [COUNTER_BITS-1:0] CNT_MAX   = {COUNTER_BITS{1'b1}};
  localparam logic [TIME_BITS-1:0]    TIME_HALF = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic [13:0]             MISS_SCALE = 14'd10000;
  localparam logic [2:0]              LAST_CH    = 3'(NCH - 1);

  localparam logic [2:0] REG_WIN_LEN      = 3'd0;
  localparam logic [2:0] REG_EXP_ACCEL    = 3'd1;
  localparam logic [2:0] REG_EXP_GYRO     = 3'd2;
  localparam logic [2:0] REG_EXP_HUMIDITY = 3'd3;
  localparam logic [2:0] REG_EXP_MAGNET   = 3'd4;
  localparam logic [2:0] REG_EXP_PRESSURE = 3'd5;

  localparam logic [31:0] RST_WIN_LEN      = 32'd4000000;
  localparam logic [15:0] RST_EXP_ACCEL    = 16'd104;
  localparam logic [15:0] RST_EXP_GYRO     = 16'd50;
  localparam logic [15:0] RST_EXP_HUMIDITY = 16'd4;
  localparam logic [15:0] RST_EXP_MAGNET   = 16'd5;
  localparam logic [15:0] RST_EXP_PRESSURE = 16'd4;

  localparam logic [2:0] CH_ACCEL    = 3'd0;
  localparam logic [2:0] CH_GYRO     = 3'd1;
  localparam logic [2:0] CH_HUMIDITY = 3'd2;
  localparam logic [2:0] CH_MAGNET   = 3'd3;
  localparam logic [2:0] CH_PRESSURE = 3'd4;

  typedef enum logic [2:0] {
    MODE_POLL    = 3'd0,
    MODE_RESERVE = 3'd1,
    MODE_QUERY   = 3'd2,
    MODE_FETCH   = 3'd3,
    MODE_START   = 3'd4
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CLOSE_CHK,
    ST_CLOSE_WAIT,
    ST_ACT,
    ST_POLL_WR,
    ST_FETCH_RD,
    ST_FETCH_MUL,
    ST_FETCH_DIV,
    ST_FETCH_WAIT,
    ST_FETCH_OUT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [2:0]  channel;
    logic [7:0]  status_byte;
    logic [47:0] time_us;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        accepted;
    logic        report_ready;
    logic [2:0]  report_channel;
    logic [15:0] captured_count;
    logic [15:0] duplicate_count;
    logic [15:0] overrun_count;
    logic [15:0] expected_count;
    logic [13:0] miss_hundredths;
    logic [15:0] accel_inputs;
    logic [47:0] report_start_us;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [COUNTER_BITS-1:0] cap;
    logic [COUNTER_BITS-1:0] dup;
    logic [COUNTER_BITS-1:0] ovr;
  } cnt_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quot;
    logic [DIV_DW-1:0] rem;
  } div_rsp_t;

  function automatic logic [COUNTER_BITS-1:0] sat_inc(logic [COUNTER_BITS-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [15:0] sat16(logic [COUNTER_BITS-1:0] v);
    logic [COUNTER_BITS+15:0] ext;
    ext = {16'b0, v};
    return (ext > (COUNTER_BITS+16)'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic logic [7:0] data_mask(logic [2:0] ch);
    logic [7:0] m;
    unique case (ch)
      CH_ACCEL:    m = 8'h01;
      CH_GYRO:     m = 8'h02;
      CH_HUMIDITY: m = 8'h03;
      CH_MAGNET:   m = 8'h08;
      CH_PRESSURE: m = 8'h02;
      default:     m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] over_mask(logic [2:0] ch);
    logic [7:0] m;
    unique case (ch)
      CH_MAGNET:   m = 8'h80;
      CH_PRESSURE: m = 8'h20;
      default:     m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/sensor_ready_window_monitor_core.sv @@
// ----------------------------------------------------------------------------
// sensor_ready_window_monitor_core
// Per-window data-ready accounting for five sensor channels.
// ----------------------------------------------------------------------------
// One word in is handled at a time. When a window closes, the window catch-up
// remainder is worked out in the shared bit-serial divider. A fetch with a
// pending report makes one divider pass per channel for the miss share. The
// counter banks live in one synchronous memory; a window close swaps the
// current and report banks when no report is pending and clears the new
// current bank at once.
// The next word is taken while the last result still waits at the output.
module sensor_ready_window_monitor_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  srwm_pkg::in_t    in_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output srwm_pkg::out_t   out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [31:0]      cfg_wdata_i
);
  import srwm_pkg::*;

  state_e state_q, state_d;
  in_t    in_q, in_d;
  logic   acc_q, acc_d;
  logic [2:0] k_q, k_d;
  logic   running_q, running_d;
  logic   pending_q, pending_d;
  logic   bank_q, bank_d;
  logic [TIME_BITS-1:0]    ws_q, ws_d, rws_q, rws_d;
  logic [COUNTER_BITS-1:0] accr_q, accr_d, raccr_q, raccr_d;
  logic [15:0] valid_q, valid_d;
  cnt_t   fcnt_q, fcnt_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [13:0] share_q, share_d;
  out_t   out_q, out_d;
  logic   out_valid_q, out_valid_d;

  logic [31:0] win_len_q;
  logic [15:0] exp_q [NCH];

  cnt_t       mem [16];
  cnt_t       rdata_q;
  logic       rvalid_q;
  logic [3:0] mem_raddr, mem_waddr;
  logic       mem_we;
  cnt_t       mem_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [TIME_BITS-1:0] t, len_t, elapsed, back;
  logic [31:0] len_eff;
  logic        close_need, is_late, late_ok, quota_ok, slot_free, ch_ok, nb;
  cnt_t        cnt_rd, cnt_up;
  logic [15:0] exp_k, missed;

  srwm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign t          = TIME_BITS'(in_q.time_us);
  assign len_eff    = (win_len_q == '0) ? 32'd1 : win_len_q;
  assign len_t      = TIME_BITS'(len_eff);
  assign elapsed    = t - ws_q;
  assign back       = ws_q - t;
  assign close_need = running_q && (elapsed >= len_t);
  assign is_late    = (back != '0) && (back <= TIME_HALF);
  assign late_ok    = pending_q && ((t - rws_q) < len_t) &&
                      (32'(raccr_q) < 32'(exp_q[0]));
  assign quota_ok   = 32'(accr_q) < 32'(exp_q[0]);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign ch_ok      = in_q.channel < 3'(NCH);
  assign nb         = pending_q ? bank_q : ~bank_q;
  assign cnt_rd     = rvalid_q ? rdata_q : '0;
  assign exp_k      = exp_q[k_q];
  assign missed     = (32'(cnt_rd.cap) < 32'(exp_k)) ?
                      16'(32'(exp_k) - 32'(cnt_rd.cap)) : 16'd0;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    cnt_up = cnt_rd;
    if ((in_q.status_byte & data_mask(in_q.channel)) != 8'h00) begin
      cnt_up.cap = sat_inc(cnt_rd.cap);
    end else begin
      cnt_up.dup = sat_inc(cnt_rd.dup);
    end
    if ((in_q.status_byte & over_mask(in_q.channel)) != 8'h00) begin
      cnt_up.ovr = sat_inc(cnt_rd.ovr);
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (in_q.mode)
          MODE_POLL:    state_d = running_q ? ST_CLOSE_CHK : ST_EMIT;
          MODE_RESERVE: state_d = (running_q && !is_late) ? ST_CLOSE_CHK : ST_EMIT;
          MODE_QUERY, MODE_FETCH: state_d = ST_CLOSE_CHK;
          default:      state_d = ST_EMIT;
        endcase
      end
      ST_CLOSE_CHK:  state_d = close_need ? ST_CLOSE_WAIT : ST_ACT;
      ST_CLOSE_WAIT: begin
        if (div_rsp.done) state_d = ST_ACT;
      end
      ST_ACT: begin
        unique case (in_q.mode)
          MODE_POLL:  state_d = ch_ok ? ST_POLL_WR : ST_EMIT;
          MODE_FETCH: state_d = (running_q && pending_q) ? ST_FETCH_RD : ST_EMIT;
          default:    state_d = ST_EMIT;
        endcase
      end
      ST_POLL_WR:    state_d = ST_EMIT;
      ST_FETCH_RD:   state_d = ST_FETCH_MUL;
      ST_FETCH_MUL:  state_d = ST_FETCH_DIV;
      ST_FETCH_DIV:  state_d = ST_FETCH_WAIT;
      ST_FETCH_WAIT: begin
        if (div_rsp.done) state_d = ST_FETCH_OUT;
      end
      ST_FETCH_OUT: begin
        if (slot_free) state_d = (k_q == LAST_CH) ? ST_IDLE : ST_FETCH_RD;
      end
      ST_EMIT: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    in_d        = in_q;
    acc_d       = acc_q;
    k_d         = k_q;
    running_d   = running_q;
    pending_d   = pending_q;
    bank_d      = bank_q;
    ws_d        = ws_q;
    rws_d       = rws_q;
    accr_d      = accr_q;
    raccr_d     = raccr_q;
    valid_d     = valid_q;
    fcnt_d      = fcnt_q;
    prod_d      = prod_q;
    share_d     = share_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_raddr   = {bank_q, in_q.channel};
    mem_waddr   = {bank_q, in_q.channel};
    mem_we      = 1'b0;
    mem_wdata   = cnt_up;
    div_req     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_d  = in_i;
          acc_d = 1'b0;
        end
      end
      ST_DISPATCH: begin
        if (in_q.mode == MODE_START) begin
          ws_d      = t;
          running_d = 1'b1;
          acc_d     = 1'b1;
        end else if (in_q.mode == MODE_RESERVE && running_q && is_late && late_ok) begin
          raccr_d = sat_inc(raccr_q);
          acc_d   = 1'b1;
        end
      end
      ST_CLOSE_CHK: begin
        div_req.start    = close_need;
        div_req.dividend = DIV_NW'(elapsed);
        div_req.divisor  = len_eff;
      end
      ST_CLOSE_WAIT: begin
        if (div_rsp.done) begin
          ws_d = t - TIME_BITS'(div_rsp.rem);
          if (!pending_q) begin
            bank_d    = ~bank_q;
            raccr_d   = accr_q;
            rws_d     = ws_q;
            pending_d = 1'b1;
          end
          for (int i = 0; i < 8; i++) begin
            valid_d[{nb, 3'(i)}] = 1'b0;
          end
          accr_d = '0;
        end
      end
      ST_ACT: begin
        if (in_q.mode == MODE_RESERVE && quota_ok) begin
          accr_d = sat_inc(accr_q);
          acc_d  = 1'b1;
        end
        k_d = '0;
      end
      ST_POLL_WR: begin
        mem_we             = 1'b1;
        valid_d[mem_waddr] = 1'b1;
        acc_d              = 1'b1;
      end
      ST_FETCH_RD: begin
        mem_raddr = {~bank_q, k_q};
      end
      ST_FETCH_MUL: begin
        fcnt_d = cnt_rd;
        prod_d = PROD_W'(PROD_W'(missed) * PROD_W'(MISS_SCALE));
      end
      ST_FETCH_DIV: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_NW'(prod_q);
        div_req.divisor  = DIV_DW'(exp_k);
      end
      ST_FETCH_WAIT: begin
        if (div_rsp.done) share_d = (exp_k == '0) ? 14'd0 : div_rsp.quot[13:0];
      end
      ST_FETCH_OUT: begin
        if (slot_free) begin
          out_valid_d           = 1'b1;
          out_d                 = '0;
          out_d.kind            = in_q.mode;
          out_d.report_ready    = 1'b1;
          out_d.report_channel  = k_q;
          out_d.captured_count  = sat16(fcnt_q.cap);
          out_d.duplicate_count = sat16(fcnt_q.dup);
          out_d.overrun_count   = sat16(fcnt_q.ovr);
          out_d.expected_count  = exp_k;
          out_d.miss_hundredths = share_q;
          out_d.accel_inputs    = sat16(raccr_q);
          out_d.report_start_us = 48'(rws_q);
          out_d.last            = (k_q == LAST_CH);
          if (k_q == LAST_CH) begin
            pending_d = 1'b0;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d              = '0;
          out_d.kind         = in_q.mode;
          out_d.accepted     = acc_q;
          out_d.report_ready = running_q && pending_q;
          out_d.last         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      pending_q   <= 1'b0;
      bank_q      <= 1'b0;
      ws_q        <= '0;
      rws_q       <= '0;
      accr_q      <= '0;
      raccr_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      acc_q       <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      running_q   <= running_d;
      pending_q   <= pending_d;
      bank_q      <= bank_d;
      ws_q        <= ws_d;
      rws_q       <= rws_d;
      accr_q      <= accr_d;
      raccr_q     <= raccr_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q    <= in_d;
    fcnt_q  <= fcnt_d;
    prod_q  <= prod_d;
    share_q <= share_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q  <= mem[mem_raddr];
    rvalid_q <= valid_q[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= RST_WIN_LEN;
      exp_q[0]  <= RST_EXP_ACCEL;
      exp_q[1]  <= RST_EXP_GYRO;
      exp_q[2]  <= RST_EXP_HUMIDITY;
      exp_q[3]  <= RST_EXP_MAGNET;
      exp_q[4]  <= RST_EXP_PRESSURE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIN_LEN:      win_len_q <= cfg_wdata_i;
        REG_EXP_ACCEL:    exp_q[0]  <= cfg_wdata_i[15:0];
        REG_EXP_GYRO:     exp_q[1]  <= cfg_wdata_i[15:0];
        REG_EXP_HUMIDITY: exp_q[2]  <= cfg_wdata_i[15:0];
        REG_EXP_MAGNET:   exp_q[3]  <= cfg_wdata_i[15:0];
        REG_EXP_PRESSURE: exp_q[4]  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/srwm_div.sv @@
// ----------------------------------------------------------------------------
// srwm_div
// Restoring divider, one quotient bit per cycle, quotient and remainder.
// ----------------------------------------------------------------------------
module srwm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  srwm_pkg::div_req_t req_i,
  output srwm_pkg::div_rsp_t rsp_o
);
  import srwm_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic [DIV_DW-1:0] rem_q, rem_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [DIV_DW-1:0] dvs_q, dvs_d;
  logic [DIV_DW:0]   cand;
  logic [DIV_DW:0]   diff;
  logic              ge;

  assign cand = {rem_q, quo_q[DIV_NW-1]};
  assign diff = cand - {1'b0, dvs_q};
  assign ge   = cand >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CW'(DIV_NW);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_DW-1:0] : cand[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule
